@@ sv/sfm_pkg.sv @@
// ----------------------------------------------------------------------------
// sfm_pkg: shared types and codes for the substring first-match finder
// Holds the action codes of the input beat and the control bundle that the
// top level hands to every compare cell.
// ----------------------------------------------------------------------------
package sfm_pkg;

    // Action codes of one input beat
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_TEXT   = 2'd2;

    // Character byte width
    localparam int unsigned BYTE_W = 8;

    // Result index width at the port
    localparam int unsigned START_W = 10;

    // Per-cycle control broadcast to the cell row
    typedef struct packed {
        logic shift_text;   // shift a text byte into the window
        logic clear_text;   // end of text: window returns to zero
        logic load_pat;     // shift a pattern byte into the pattern row
    } cell_ctrl_t;

endpackage

@@ sv/sfm_cell.sv @@
// ----------------------------------------------------------------------------
// sfm_cell: one compare cell of the search row
// Holds one text window byte and one pattern byte, passes both to its right
// neighbor and flags whether its incoming text byte matches its pattern byte.
// ----------------------------------------------------------------------------
module sfm_cell
    import sfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctrl_t          ctrl,
    input  logic                active,
    input  logic [BYTE_W-1:0]   text_in,
    input  logic [BYTE_W-1:0]   pat_in,
    output logic [BYTE_W-1:0]   text_out,
    output logic [BYTE_W-1:0]   pat_out,
    output logic                match
);

    logic [BYTE_W-1:0] text_reg;
    logic [BYTE_W-1:0] text_next;
    logic [BYTE_W-1:0] pat_reg;
    logic [BYTE_W-1:0] pat_next;

    // Window byte: cleared at end of text, shifted on each text beat
    always_comb
    begin
        text_next = text_reg;
        if (ctrl.clear_text)
        begin
            text_next = '0;
        end
        else if (ctrl.shift_text)
        begin
            text_next = text_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_reg <= '0;
        end
        else
        begin
            text_reg <= text_next;
        end
    end

    // Pattern byte: newest pattern byte sits in cell 0
    assign pat_next = ctrl.load_pat ? pat_in : pat_reg;

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    // Compare against the byte arriving this cycle; idle cells always agree
    assign match    = !active || (text_in == pat_reg);
    assign text_out = text_reg;
    assign pat_out  = pat_reg;

endmodule

@@ sv/substring_first_match_finder.sv @@
// ----------------------------------------------------------------------------
// substring_first_match_finder: streaming first-occurrence substring search
// Loads a pattern byte by byte, then scans a text stream for its first match.
// ----------------------------------------------------------------------------
// An input beat can be accepted every cycle in which in_stall is low.
// Pattern beats shift into a row of PATTERN_MAX cells; text beats shift into
// the same row's window, and all cells compare in parallel with the stored
// pattern in the cycle the text byte arrives. The result of a text beat
// marked last is presented on the next cycle from an output register; input
// is stalled only while that register holds a result whose consumer stalls.
// The start index counts text bytes from zero; the text position saturates
// at TEXT_MAX-1. Empty patterns never match; appends past PATTERN_MAX drop.
// ----------------------------------------------------------------------------
module substring_first_match_finder
    import sfm_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 16,
    parameter int unsigned TEXT_MAX    = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [BYTE_W-1:0]   byte_value,
    input  logic                last_text,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output logic [START_W-1:0]  match_start
);

    localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int unsigned IDX_W = $clog2(TEXT_MAX);
    localparam int unsigned CMP_W = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 1;

    cell_ctrl_t             ctrl;
    logic                   accept;
    logic                   text_beat;
    logic                   full;

    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic [IDX_W-1:0]       pos_reg;
    logic [IDX_W-1:0]       pos_next;
    logic                   seen_reg;
    logic                   seen_next;
    logic [IDX_W-1:0]       first_reg;
    logic [IDX_W-1:0]       first_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   found_reg;
    logic                   found_next;
    logic [START_W-1:0]     start_reg;
    logic [START_W-1:0]     start_next;

    logic [BYTE_W-1:0]      text_chain [PATTERN_MAX+1];
    logic [BYTE_W-1:0]      pat_chain  [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] match_vec;
    logic [PATTERN_MAX-1:0] active_vec;

    logic [CMP_W-1:0]       count_ext;
    logic [CMP_W-1:0]       len_ext;
    logic [CMP_W-1:0]       start_ext;
    logic                   hit;
    logic [IDX_W+START_W-1:0] start_wide;

    // Handshake: hold input only while a result waits on a stalled consumer
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign text_beat = accept && (action == ACT_TEXT);
    assign full      = (len_reg == LEN_W'(PATTERN_MAX));

    assign ctrl.shift_text = text_beat;
    assign ctrl.clear_text = text_beat && last_text;
    assign ctrl.load_pat   = accept && (action == ACT_APPEND) && !full;

    // Cell row
    assign text_chain[0] = byte_value;
    assign pat_chain[0]  = byte_value;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        assign active_vec[k] = (LEN_W'(k) < len_reg);

        sfm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .active   (active_vec[k]),
            .text_in  (text_chain[k]),
            .pat_in   (pat_chain[k]),
            .text_out (text_chain[k+1]),
            .pat_out  (pat_chain[k+1]),
            .match    (match_vec[k])
        );
    end

    // Match test: first match only, whole pattern present and enough text seen
    assign count_ext = {{(CMP_W-IDX_W){1'b0}}, pos_reg} + CMP_W'(1);
    assign len_ext   = {{(CMP_W-LEN_W){1'b0}}, len_reg};
    assign start_ext = count_ext - len_ext;
    assign hit       = !seen_reg && (len_reg != '0) && (count_ext >= len_ext) && (&match_vec);

    // Pattern length
    always_comb
    begin
        len_next = len_reg;
        if (accept && (action == ACT_CLEAR))
        begin
            len_next = '0;
        end
        else if (ctrl.load_pat)
        begin
            len_next = len_reg + LEN_W'(1);
        end
    end

    // Text position and first-match tracking
    always_comb
    begin
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        first_next = first_reg;
        if (ctrl.clear_text)
        begin
            pos_next   = '0;
            seen_next  = 1'b0;
            first_next = '0;
        end
        else if (text_beat)
        begin
            if (pos_reg != IDX_W'(TEXT_MAX - 1))
            begin
                pos_next = pos_reg + IDX_W'(1);
            end
            if (hit)
            begin
                seen_next  = 1'b1;
                first_next = start_ext[IDX_W-1:0];
            end
        end
    end

    // Result register
    assign start_wide = seen_reg ? {{START_W{1'b0}}, first_reg}
                                 : {{START_W{1'b0}}, start_ext[IDX_W-1:0]};

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        found_next     = found_reg;
        start_next     = start_reg;
        if (ctrl.clear_text)
        begin
            out_valid_next = 1'b1;
            found_next     = seen_reg || hit;
            start_next     = (seen_reg || hit) ? start_wide[START_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            first_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        start_reg <= start_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_start = start_reg;

endmodule

@@ sv/sfm_checker.sv @@
// ----------------------------------------------------------------------------
// sfm_checker: port-level checks for the substring first-match finder
// Watches the top-level ports and flags result beats and input stalls that
// break the block's timing or value rules.
// ----------------------------------------------------------------------------
module sfm_checker
    import sfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          action,
    input  logic                last_text,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                found,
    input  logic [START_W-1:0]  match_start
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_start))
        else $error("result beat changed while stalled");

    // Not-found results carry a zero start index
    a_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_start == '0)
        else $error("not-found result with nonzero start");

    // Input is held back only by a waiting, stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a pending result");

    // A new result appears in the cycle after an accepted last text beat
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && (action == ACT_TEXT) && last_text))
        else $error("result beat without a last text beat");

endmodule

bind substring_first_match_finder sfm_checker u_sfm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .last_text   (last_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .match_start (match_start)
);
